// ----- rtl/core/vrl_pkg.sv -----
`default_nettype none

package vrl_pkg;

  // field widths
  localparam int unsigned LimitW   = 24;
  localparam int unsigned CapW     = 32;
  localparam int unsigned BudgetW  = 32;  // limit times a period of at most 255 seconds
  localparam int unsigned CountW   = 16;
  localparam int unsigned PendingW = 48;
  localparam int unsigned WrittenW = 48;
  localparam int unsigned SecW     = 8;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  // request kinds carried in the input tuser
  typedef enum logic [1:0] {
    REQ_COLLECTED = 2'd0,
    REQ_WRITTEN   = 2'd1,
    REQ_TICK      = 2'd2,
    REQ_NONE      = 2'd3
  } req_type_e;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PER_SECOND_LIMIT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_OVERCOMMIT_CAP   = 1'd1;

  localparam logic [SecW-1:0]     SecMax     = '1;
  localparam logic [PendingW-1:0] PendingMax = '1;

endpackage

`default_nettype wire

// ----- rtl/core/value_rate_limiter_with_overcommit_core.sv -----
`default_nettype none

// channel    dir  payload                                              handshake
// s_axis     in   tdata: value_count[15:0]; tuser: req_type[1:0]      tvalid/tready
// m_axis     out  tdata: overcommit_used, pending_values,             tvalid/tready
//                 written_total; tuser: capped
// cfg        in   cfg_idx_i selects register, cfg_wdata_i data         cfg_we_i, no wait
//
// one word per cycle sustained while results are taken; a word passes through the input
// register and is then settled into the state/result registers
// the per-period budget is multiplied out when the limit register is written
// reset clears all counters, the configuration and both valid flags
// a stalled result holds the state; the input register still takes one word meanwhile

module value_rate_limiter_with_overcommit_core
  import vrl_pkg::*;
#(
  parameter int unsigned PERIOD_SECONDS = 10  // 1 to 255
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [CfgDataW-1:0]   cfg_wdata_i,

  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [15:0]           s_axis_tdata_i,   // value_count[15:0]
  input  wire logic [1:0]            s_axis_tuser_i,   // req_type[1:0]

  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [127:0]               m_axis_tdata_o,   // overcommit_used[31:0],
                                                       // pending_values[79:32],
                                                       // written_total[127:80]
  output logic [0:0]                 m_axis_tuser_o    // capped
);

  localparam logic [SecW-1:0] PeriodSec = SecW'(PERIOD_SECONDS);

  // configuration
  logic [LimitW-1:0]  limit_q;
  logic [CapW-1:0]    cap_q;
  logic [BudgetW-1:0] budget_q;

  // input register
  logic              in_vld_q;
  req_type_e         in_type_q;
  logic [CountW-1:0] in_count_q;

  // state, doubling as the result register
  logic                out_vld_q;
  logic                capped_q, capped_d;
  logic [PendingW-1:0] pending_q, pending_d;
  logic [CapW-1:0]     charge_q, charge_d;
  logic [SecW-1:0]     sec_q, sec_d;
  logic [WrittenW-1:0] written_q, written_d;

  logic adv;
  logic load_in;

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_vld_q || adv;
  assign load_in         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= '0;
      cap_q    <= '0;
      budget_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PER_SECOND_LIMIT: begin
          limit_q  <= cfg_wdata_i[LimitW-1:0];
          budget_q <= BudgetW'({8'd0, cfg_wdata_i[LimitW-1:0]} * {24'd0, PeriodSec});
        end
        CFG_OVERCOMMIT_CAP: cap_q <= cfg_wdata_i[CapW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      in_type_q  <= req_type_e'(s_axis_tuser_i);
      in_count_q <= s_axis_tdata_i;
    end
  end

  // settle, count, seconds tick and cap check for the word in the input register
  always_comb begin
    logic [CapW-1:0]       credit_old;
    logic [CapW-1:0]       credit_new;
    logic [BudgetW-1:0]    spare;
    logic [BudgetW:0]      reach;
    logic [BudgetW:0]      reach_new;
    logic [PendingW-1:0]   budget_x;
    logic [PendingW:0]     sum;

    pending_d = pending_q;
    charge_d  = charge_q;
    sec_d     = sec_q;
    written_d = written_q;
    sum       = '0;
    budget_x  = {{(PendingW-BudgetW){1'b0}}, budget_q};

    credit_old = (cap_q > charge_q) ? cap_q - charge_q : '0;
    spare      = budget_q - pending_q[BudgetW-1:0];
    reach      = {1'b0, budget_q} + {1'b0, credit_old};

    case (in_type_q)
      REQ_COLLECTED: begin
        if (limit_q != '0) begin
          if (sec_q >= PeriodSec) begin
            sec_d = '0;
            if (pending_q < budget_x) begin
              // under-use repays the charge
              charge_d  = (charge_q > spare) ? charge_q - spare : '0;
              pending_d = '0;
            end else if (pending_q <= {15'd0, reach}) begin
              // over-use fits in the credit
              charge_d  = charge_q + CapW'(pending_q - budget_x);
              pending_d = '0;
            end else begin
              // credit exhausted, excess carries over
              pending_d = pending_q - {15'd0, reach};
              charge_d  = cap_q;
            end
          end
          sum       = {1'b0, pending_d} + {{(PendingW+1-CountW){1'b0}}, in_count_q};
          pending_d = sum[PendingW] ? PendingMax : sum[PendingW-1:0];
        end
      end
      REQ_WRITTEN: begin
        written_d = written_q + {{(WrittenW-CountW){1'b0}}, in_count_q};
      end
      REQ_TICK: begin
        if (sec_q != SecMax) sec_d = sec_q + 1'b1;
      end
      default: ;
    endcase

    credit_new = (cap_q > charge_d) ? cap_q - charge_d : '0;
    reach_new  = {1'b0, budget_q} + {1'b0, credit_new};
    capped_d   = (budget_q != '0) && (pending_d >= budget_x) &&
                 (pending_d > {15'd0, reach_new});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      capped_q  <= 1'b0;
      pending_q <= '0;
      charge_q  <= '0;
      sec_q     <= '0;
      written_q <= '0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
      if (in_vld_q) begin
        capped_q  <= capped_d;
        pending_q <= pending_d;
        charge_q  <= charge_d;
        sec_q     <= sec_d;
        written_q <= written_d;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {written_q, pending_q, charge_q};
  assign m_axis_tuser_o  = capped_q;

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import vrl_pkg::*;

  localparam int unsigned PeriodSec  = 10;
  // slowest legal run: ~1170 words, each at worst a long sender gap plus a long
  // receiver stall plus its pass through the block, plus one long hold-off and the
  // config pauses; this limit lies several times over that
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned HoldAt     = 900;   // results seen before the long hold-off
  localparam int unsigned HoldLen    = 250;   // cycles the receiver holds off

  // one input word as the block sees it
  typedef struct packed {
    req_type_e   kind;
    logic [15:0] count;
  } acct_word_t;

  // one result word, unpacked from tdata/tuser
  typedef struct packed {
    logic                capped;
    logic [CapW-1:0]     overcommit;
    logic [PendingW-1:0] pending;
    logic [WrittenW-1:0] written;
  } rate_result_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i       = '0;
  logic [CfgDataW-1:0] cfg_wdata_i     = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [15:0]         s_axis_tdata_i  = '0;  // value_count[15:0]
  logic [1:0]          s_axis_tuser_i  = '0;  // req_type[1:0]
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [127:0]        m_axis_tdata_o;        // overcommit_used, pending_values, written_total
  logic [0:0]          m_axis_tuser_o;        // capped

  value_rate_limiter_with_overcommit_core #(
    .PERIOD_SECONDS(PeriodSec)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #4 clk_i = ~clk_i;

  // words waiting to be offered, and results the accounting model predicts
  acct_word_t   offered_words[$];
  rate_result_t predicted_results[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // accounting model: configuration copy and state
  logic [LimitW-1:0]   limit_q   = '0;
  logic [CapW-1:0]     cap_q     = '0;
  logic [PendingW-1:0] pend_q    = '0;
  logic [CapW-1:0]     charge_q  = '0;
  logic [SecW-1:0]     secs_q    = '0;
  logic [WrittenW-1:0] written_q = '0;

  // credit still free under the cap; zero when the charge sits above a lowered cap
  function automatic logic [63:0] credit_avail();
    return (cap_q > charge_q) ? 64'(cap_q - charge_q) : 64'd0;
  endfunction

  // advance the model by one accepted word and return the result it reports
  function automatic rate_result_t account_word(acct_word_t w);
    logic [63:0]  budget;
    logic [63:0]  avail;
    logic [63:0]  spare;
    rate_result_t r;
    budget = 64'(limit_q) * PeriodSec;
    case (w.kind)
      REQ_COLLECTED: begin
        // a zero limit turns collected accounting off entirely
        if (limit_q != '0) begin
          if (secs_q >= PeriodSec) begin
            // settle the period that just ended
            if (budget > 64'(pend_q)) begin
              // under-use pays back the charge
              spare    = budget - 64'(pend_q);
              charge_q = (64'(charge_q) > spare) ? charge_q - 32'(spare) : '0;
              pend_q   = '0;
            end else begin
              avail = credit_avail();
              if (64'(pend_q) <= budget + avail) begin
                // over-use fits in the credit
                charge_q = 32'(64'(charge_q) + 64'(pend_q) - budget);
                pend_q   = '0;
              end else begin
                // credit runs out, the rest carries into the new period
                pend_q   = 48'(64'(pend_q) - budget - avail);
                charge_q = cap_q;
              end
            end
            secs_q = '0;
          end
          // pending saturates instead of wrapping
          if (PendingMax - pend_q < 48'(w.count)) pend_q = PendingMax;
          else pend_q = pend_q + 48'(w.count);
        end
      end
      REQ_WRITTEN: written_q = written_q + 48'(w.count);  // wraps at 48 bits
      REQ_TICK: if (secs_q != SecMax) secs_q = secs_q + 1'b1;
      default: ;  // unknown kind leaves the state alone
    endcase
    r.capped     = (budget == 0 || 64'(pend_q) < budget) ? 1'b0 :
                   (64'(pend_q) > budget + credit_avail());
    r.overcommit = charge_q;
    r.pending    = pend_q;
    r.written    = written_q;
    return r;
  endfunction

  // sender: offers queued words, predicts each one as it is taken;
  // idles 32% for the first 400 words, 75% up to 800, then never
  always @(posedge clk_i) begin
    int unsigned accepted;
    int unsigned idle_pct;
    acct_word_t  w;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      accepted = 0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (s_axis_tvalid_i) begin
        w.kind  = req_type_e'(s_axis_tuser_i);
        w.count = s_axis_tdata_i;
        predicted_results.push_back(account_word(w));
        accepted++;
      end
      idle_pct = (accepted < 400) ? 32 : (accepted < 800) ? 75 : 0;
      if (offered_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
        w = offered_words.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= w.count;
        s_axis_tuser_i  <= w.kind;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver and checker: compares each taken result with the oldest prediction;
  // stalls 75% for the first 400 results, 32% up to 800, then never, except for
  // one long hold-off that lets the block fill up and push back on its input
  always @(posedge clk_i) begin
    int unsigned  seen;
    int unsigned  hold_left;
    bit           hold_done;
    int unsigned  stall_pct;
    rate_result_t got;
    rate_result_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      seen      = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.capped     = m_axis_tuser_o[0];
        got.overcommit = m_axis_tdata_o[31:0];
        got.pending    = m_axis_tdata_o[79:32];
        got.written    = m_axis_tdata_o[127:80];
        seen++;
        if (predicted_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] unexpected result: capped=%0d overcommit=%0d pending=%0d written=%0d",
                     $realtime, got.capped, got.overcommit, got.pending, got.written);
        end else begin
          want = predicted_results.pop_front();
          if (got.capped !== want.capped || got.overcommit !== want.overcommit ||
              got.pending !== want.pending || got.written !== want.written) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $write("[%0t] result %0d mismatch: capped %0d/%0d overcommit %0d/%0d ",
                     $realtime, seen, want.capped, got.capped, want.overcommit,
                     got.overcommit);
              $display("pending %0d/%0d written %0d/%0d (expected/actual)",
                       want.pending, got.pending, want.written, got.written);
            end
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!hold_done && seen >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldLen - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        stall_pct = (seen < 400) ? 75 : (seen < 800) ? 32 : 0;
        m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic queue_word(req_type_e kind, logic [15:0] count);
    acct_word_t w;
    w.kind  = kind;
    w.count = count;
    offered_words.push_back(w);
  endtask

  // register write, only ever issued while the block is idle
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_PER_SECOND_LIMIT) limit_q = data[LimitW-1:0];
    else cap_q = data[CapW-1:0];
  endtask

  // wait until every word is taken and every result is back, plus some margin
  task automatic wait_idle();
    @(negedge clk_i);
    while (offered_words.size() != 0 || s_axis_tvalid_i || predicted_results.size() != 0)
      @(negedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // random accounting traffic; counts mostly up to span, with zero and full
  // scale mixed in; ticks sometimes come as a whole period in a row
  task automatic run_random(int unsigned n, int unsigned span, int unsigned tick_pct);
    int unsigned pushed;
    int unsigned r;
    logic [15:0] cnt;
    pushed = 0;
    @(negedge clk_i);
    while (pushed < n) begin
      r = $urandom_range(99);
      if (r < 8) cnt = '0;
      else if (r < 14) cnt = '1;
      else cnt = 16'($urandom_range(span));
      if ($urandom_range(99) < tick_pct) begin
        if ($urandom_range(99) < 20) begin
          repeat (PeriodSec) queue_word(REQ_TICK, 16'($urandom));
          pushed += PeriodSec;
        end else begin
          queue_word(REQ_TICK, 16'($urandom));
          pushed++;
        end
      end else begin
        r = $urandom_range(99);
        if (r < 70) queue_word(REQ_COLLECTED, cnt);
        else if (r < 92) queue_word(REQ_WRITTEN, cnt);
        else queue_word(REQ_NONE, 16'($urandom));
        pushed++;
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // limit still zero: collected words change nothing, the rest still work
    queue_word(REQ_COLLECTED, 16'hFFFF);
    queue_word(REQ_WRITTEN, 16'hFFFF);
    queue_word(REQ_TICK, 16'h0000);
    queue_word(REQ_NONE, 16'hFFFF);
    wait_idle();

    // budget 20, credit 30: fill past budget plus credit, then settle with
    // the excess carried over and the charge pinned at the cap
    write_reg(CFG_PER_SECOND_LIMIT, 32'd2);
    write_reg(CFG_OVERCOMMIT_CAP, 32'd30);
    @(negedge clk_i);
    queue_word(REQ_COLLECTED, 16'd40);
    queue_word(REQ_COLLECTED, 16'd15);
    repeat (PeriodSec) queue_word(REQ_TICK, 16'hFFFF);
    queue_word(REQ_COLLECTED, 16'd0);
    wait_idle();

    // limit off again with mostly ticks, so the seconds counter saturates
    write_reg(CFG_PER_SECOND_LIMIT, 32'd0);
    write_reg(CFG_OVERCOMMIT_CAP, 32'd1234);
    run_random(300, 65535, 85);

    // tiny budget, no credit at all
    write_reg(CFG_PER_SECOND_LIMIT, 32'd1);
    write_reg(CFG_OVERCOMMIT_CAP, 32'd0);
    run_random(150, 20, 35);

    // generous credit builds up a large charge
    write_reg(CFG_PER_SECOND_LIMIT, 32'd50);
    write_reg(CFG_OVERCOMMIT_CAP, 32'd5000);
    run_random(200, 300, 30);

    // cap lowered under the charge already built up
    write_reg(CFG_OVERCOMMIT_CAP, 32'd100);
    run_random(150, 300, 30);

    // both registers at full scale; the long hold-off falls in this phase
    write_reg(CFG_PER_SECOND_LIMIT, 32'hFFFFFF);
    write_reg(CFG_OVERCOMMIT_CAP, 32'hFFFFFFFF);
    run_random(150, 65535, 30);

    // larger budget with no credit, then a small budget with some credit
    write_reg(CFG_PER_SECOND_LIMIT, 32'd3000);
    write_reg(CFG_OVERCOMMIT_CAP, 32'd0);
    run_random(100, 65535, 30);

    write_reg(CFG_PER_SECOND_LIMIT, 32'd7);
    write_reg(CFG_OVERCOMMIT_CAP, 32'd65);
    run_random(100, 40, 35);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatch_count == 0 && predicted_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
